>>> src/mste_pkg.sv
// mount slew target encoder: shared widths, constants, register codes and types
`timescale 1ns / 1ps
`default_nettype none
package mste_pkg;

    // fraction bits of a turn in the angle words
    localparam int TURN_FRACTION_BITS = 24;

    // fixed field widths
    localparam int HA_W   = 24;
    localparam int DEC_W  = 24;
    localparam int ZERO_W = 24;
    localparam int SPT_W  = 25;
    localparam int STEP_W = 26;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] REG_SOUTH_HEMISPHERE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RA_ZERO_STEPS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RA_STEPS_PER_TURN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEC_ZERO_STEPS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEC_STEPS_PER_TURN = 3'd4;

    localparam logic [ZERO_W-1:0] ZERO_STEPS_RESET     = ZERO_W'(8388608);
    localparam logic [SPT_W-1:0]  STEPS_PER_TURN_RESET = SPT_W'(16777216);

    // axis position words: two integer bits of turn headroom plus sign
    localparam int POS_W = TURN_FRACTION_BITS + 3;
    localparam logic signed [POS_W-1:0] ONE_TURN  = POS_W'(1) << TURN_FRACTION_BITS;
    localparam logic signed [POS_W-1:0] HALF_TURN = ONE_TURN >>> 1;
    localparam logic signed [POS_W-1:0] THREE_QUARTER_TURN = ONE_TURN - (ONE_TURN >>> 2);

    // step product and sum widths
    localparam int PROD_W = POS_W + SPT_W + 1;
    localparam int SHIFT_W = PROD_W - TURN_FRACTION_BITS;
    localparam int SUM_W = SHIFT_W + 1;
    localparam logic signed [SUM_W-1:0] STEP_MAX = SUM_W'((64'sd1 <<< (STEP_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] STEP_MIN = SUM_W'(-(64'sd1 <<< (STEP_W - 1)));

    // configuration register set
    typedef struct packed {
        logic              south;
        logic [ZERO_W-1:0] ra_zero;
        logic [SPT_W-1:0]  ra_spt;
        logic [ZERO_W-1:0] dec_zero;
        logic [SPT_W-1:0]  dec_spt;
    } t_cfg;

endpackage
`default_nettype wire

>>> src/mste_cfg_regs.sv
// mount slew target encoder: configuration register file
`timescale 1ns / 1ps
`default_nettype none
module mste_cfg_regs (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [mste_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [mste_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output mste_pkg::t_cfg                    o_cfg
);

    mste_pkg::t_cfg r_cfg;
    mste_pkg::t_cfg n_cfg;
    logic           r_cfg_ready;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && r_cfg_ready) begin
            unique case (i_cfg_index)
                mste_pkg::REG_SOUTH_HEMISPHERE:   n_cfg.south    = i_cfg_data[0];
                mste_pkg::REG_RA_ZERO_STEPS:
                    n_cfg.ra_zero  = i_cfg_data[mste_pkg::ZERO_W-1:0];
                mste_pkg::REG_RA_STEPS_PER_TURN:
                    n_cfg.ra_spt   = i_cfg_data[mste_pkg::SPT_W-1:0];
                mste_pkg::REG_DEC_ZERO_STEPS:
                    n_cfg.dec_zero = i_cfg_data[mste_pkg::ZERO_W-1:0];
                mste_pkg::REG_DEC_STEPS_PER_TURN:
                    n_cfg.dec_spt  = i_cfg_data[mste_pkg::SPT_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    // register state and ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.south    <= 1'b0;
            r_cfg.ra_zero  <= mste_pkg::ZERO_STEPS_RESET;
            r_cfg.ra_spt   <= mste_pkg::STEPS_PER_TURN_RESET;
            r_cfg.dec_zero <= mste_pkg::ZERO_STEPS_RESET;
            r_cfg.dec_spt  <= mste_pkg::STEPS_PER_TURN_RESET;
            r_cfg_ready    <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_cfg_ready <= 1'b1;
        end
    end

    assign o_cfg       = r_cfg;
    assign o_cfg_ready = r_cfg_ready;

endmodule
`default_nettype wire

>>> src/mste_solve.sv
// mount slew target encoder: pier side axis positions and solution order
`timescale 1ns / 1ps
`default_nettype none
module mste_solve (
    input  wire logic signed [mste_pkg::HA_W-1:0]  i_hour_angle,
    input  wire logic signed [mste_pkg::DEC_W-1:0] i_declination,
    input  wire                                    i_south,
    output logic signed [mste_pkg::POS_W-1:0]      o_normal_ra_pos,
    output logic signed [mste_pkg::POS_W-1:0]      o_normal_dec_pos,
    output logic signed [mste_pkg::POS_W-1:0]      o_flipped_ra_pos,
    output logic signed [mste_pkg::POS_W-1:0]      o_flipped_dec_pos,
    output logic                                   o_normal_is_west
);

    localparam int F = mste_pkg::TURN_FRACTION_BITS;

    logic signed [mste_pkg::POS_W-1:0] h_ext;
    logic signed [mste_pkg::POS_W-1:0] h_low;
    logic signed [mste_pkg::POS_W-1:0] h;
    logic signed [mste_pkg::POS_W-1:0] d;
    logic signed [mste_pkg::POS_W-1:0] degw_raw;
    logic signed [mste_pkg::POS_W-1:0] dege_raw;
    logic signed [mste_pkg::POS_W-1:0] degw;
    logic signed [mste_pkg::POS_W-1:0] dege;
    logic signed [mste_pkg::POS_W-1:0] haw;
    logic signed [mste_pkg::POS_W-1:0] hae;
    logic                              west_first;

    // hour angle wrapped into [-half, half) turn
    assign h_ext = mste_pkg::POS_W'(i_hour_angle);
    assign h_low = h_ext & (mste_pkg::ONE_TURN - mste_pkg::POS_W'(1));
    assign h     = h_low[F-1] ? (h_low - mste_pkg::ONE_TURN) : h_low;
    assign d     = mste_pkg::POS_W'(i_declination);

    // west and east positions by hemisphere
    always_comb begin
        if (i_south) begin
            degw_raw = d[mste_pkg::POS_W-1] ? -d : (mste_pkg::ONE_TURN - d);
            dege_raw = mste_pkg::HALF_TURN + d;
            haw      = mste_pkg::HALF_TURN - h;
            hae      = h[mste_pkg::POS_W-1] ? -h : (mste_pkg::ONE_TURN - h);
        end else begin
            degw_raw = mste_pkg::HALF_TURN - d;
            dege_raw = d[mste_pkg::POS_W-1] ? (mste_pkg::ONE_TURN + d) : d;
            haw      = h[mste_pkg::POS_W-1] ? (h + mste_pkg::ONE_TURN) : h;
            hae      = h + mste_pkg::HALF_TURN;
        end
    end

    // declination rebase above three quarters of a turn
    assign degw = (degw_raw > mste_pkg::THREE_QUARTER_TURN) ?
                  (degw_raw - mste_pkg::ONE_TURN) : degw_raw;
    assign dege = (dege_raw > mste_pkg::THREE_QUARTER_TURN) ?
                  (dege_raw - mste_pkg::ONE_TURN) : dege_raw;

    // counterweight-down side goes first
    assign west_first = haw < mste_pkg::HALF_TURN;

    assign o_normal_ra_pos   = west_first ? haw  : hae;
    assign o_normal_dec_pos  = west_first ? degw : dege;
    assign o_flipped_ra_pos  = west_first ? hae  : haw;
    assign o_flipped_dec_pos = west_first ? dege : degw;
    assign o_normal_is_west  = west_first;

endmodule
`default_nettype wire

>>> src/mste_axis_steps.sv
// mount slew target encoder: one axis position to motor steps, two register stages
`timescale 1ns / 1ps
`default_nettype none
module mste_axis_steps (
    input  wire                                   i_clk,
    input  wire logic signed [mste_pkg::POS_W-1:0] i_pos,
    input  wire        [mste_pkg::ZERO_W-1:0]     i_zero,
    input  wire        [mste_pkg::SPT_W-1:0]      i_per_turn,
    output logic signed [mste_pkg::STEP_W-1:0]    o_steps
);

    localparam int F = mste_pkg::TURN_FRACTION_BITS;

    logic signed [mste_pkg::POS_W-1:0]   pos;
    logic signed [mste_pkg::SPT_W:0]     spt_s;
    logic signed [mste_pkg::PROD_W-1:0]  prod;
    logic signed [mste_pkg::PROD_W-1:0]  r_prod;
    logic signed [mste_pkg::PROD_W-1:0]  rounded;
    logic signed [mste_pkg::SHIFT_W-1:0] shifted;
    logic signed [mste_pkg::SUM_W-1:0]   sum;
    logic signed [mste_pkg::STEP_W-1:0]  n_steps;
    logic signed [mste_pkg::STEP_W-1:0]  r_steps;

    // move down a turn above three quarters, then scale
    assign pos   = (i_pos > mste_pkg::THREE_QUARTER_TURN) ?
                   (i_pos - mste_pkg::ONE_TURN) : i_pos;
    assign spt_s = $signed({1'b0, i_per_turn});
    assign prod  = mste_pkg::PROD_W'(pos) * mste_pkg::PROD_W'(spt_s);

    // round half up, floor shift, add home offset
    assign rounded = r_prod + mste_pkg::PROD_W'(mste_pkg::HALF_TURN);
    assign shifted = rounded[mste_pkg::PROD_W-1:F];
    assign sum     = mste_pkg::SUM_W'(shifted)
                   + mste_pkg::SUM_W'($signed({1'b0, i_zero}));

    // clamp to the step word range
    always_comb begin
        if (sum > mste_pkg::STEP_MAX) begin
            n_steps = mste_pkg::STEP_MAX[mste_pkg::STEP_W-1:0];
        end else if (sum < mste_pkg::STEP_MIN) begin
            n_steps = mste_pkg::STEP_MIN[mste_pkg::STEP_W-1:0];
        end else begin
            n_steps = sum[mste_pkg::STEP_W-1:0];
        end
    end

    // product and result registers
    always_ff @(posedge i_clk) begin
        r_prod  <= prod;
        r_steps <= n_steps;
    end

    assign o_steps = r_steps;

endmodule
`default_nettype wire

>>> src/mount_slew_target_encoder_solutions_top.sv
// mount slew target encoder: top level, target to both pier side step solutions
//
//   channel   handshake                  word
//   -------   ------------------------   ------------------------------------------
//   target    i_start / o_busy           i_hour_angle, i_declination
//   result    o_strobe (one cycle)       o_normal_*, o_flipped_*, o_normal_is_west
//   config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one target per clock while o_busy is low; from accept to strobe a target passes
// the input register, the product register after each axis multiplier and the
// result register. reset is synchronous; o_busy drops and o_cfg_ready rises in
// the cycle after reset is released. the receiver cannot stall: results are shown
// for one cycle only.
`timescale 1ns / 1ps
`default_nettype none
module mount_slew_target_encoder_solutions_top (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_start,
    output logic                                    o_busy,
    input  wire logic signed [mste_pkg::HA_W-1:0]   i_hour_angle,
    input  wire logic signed [mste_pkg::DEC_W-1:0]  i_declination,
    output logic                                    o_strobe,
    output logic signed [mste_pkg::STEP_W-1:0]      o_normal_ra_steps,
    output logic signed [mste_pkg::STEP_W-1:0]      o_normal_dec_steps,
    output logic signed [mste_pkg::STEP_W-1:0]      o_flipped_ra_steps,
    output logic signed [mste_pkg::STEP_W-1:0]      o_flipped_dec_steps,
    output logic                                    o_normal_is_west,
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire        [mste_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire        [mste_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    mste_pkg::t_cfg cfg;

    logic                               r_busy;
    logic                               r_v1;
    logic                               r_v2;
    logic                               r_v3;
    logic signed [mste_pkg::HA_W-1:0]   r_hour;
    logic signed [mste_pkg::DEC_W-1:0]  r_dec;
    logic                               r_west2;
    logic                               r_west3;
    logic                               accept;

    logic signed [mste_pkg::POS_W-1:0]  normal_ra_pos;
    logic signed [mste_pkg::POS_W-1:0]  normal_dec_pos;
    logic signed [mste_pkg::POS_W-1:0]  flipped_ra_pos;
    logic signed [mste_pkg::POS_W-1:0]  flipped_dec_pos;
    logic                               west_first;

    assign accept = i_start && !r_busy;

    // configuration registers
    mste_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // control: busy only around reset, valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_v1   <= accept;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
        end
    end

    // input word and side flag registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hour <= i_hour_angle;
            r_dec  <= i_declination;
        end
        r_west2 <= west_first;
        r_west3 <= r_west2;
    end

    // pier side positions
    mste_solve u_solve (
        .i_hour_angle      (r_hour),
        .i_declination     (r_dec),
        .i_south           (cfg.south),
        .o_normal_ra_pos   (normal_ra_pos),
        .o_normal_dec_pos  (normal_dec_pos),
        .o_flipped_ra_pos  (flipped_ra_pos),
        .o_flipped_dec_pos (flipped_dec_pos),
        .o_normal_is_west  (west_first)
    );

    // step conversion, one unit per output position
    mste_axis_steps u_normal_ra (
        .i_clk      (i_clk),
        .i_pos      (normal_ra_pos),
        .i_zero     (cfg.ra_zero),
        .i_per_turn (cfg.ra_spt),
        .o_steps    (o_normal_ra_steps)
    );

    mste_axis_steps u_normal_dec (
        .i_clk      (i_clk),
        .i_pos      (normal_dec_pos),
        .i_zero     (cfg.dec_zero),
        .i_per_turn (cfg.dec_spt),
        .o_steps    (o_normal_dec_steps)
    );

    mste_axis_steps u_flipped_ra (
        .i_clk      (i_clk),
        .i_pos      (flipped_ra_pos),
        .i_zero     (cfg.ra_zero),
        .i_per_turn (cfg.ra_spt),
        .o_steps    (o_flipped_ra_steps)
    );

    mste_axis_steps u_flipped_dec (
        .i_clk      (i_clk),
        .i_pos      (flipped_dec_pos),
        .i_zero     (cfg.dec_zero),
        .i_per_turn (cfg.dec_spt),
        .o_steps    (o_flipped_dec_steps)
    );

    assign o_busy           = r_busy;
    assign o_strobe         = r_v3;
    assign o_normal_is_west = r_west3;

`ifndef NO_ASSERTIONS
    // every accepted target gives a strobe after the input, product and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_strobe)
        else $error("accepted target did not produce a result");

    // product stage always drains into the result register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |=> o_strobe)
        else $error("product stage word lost");

    // no strobe without an input register word that fed it
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !$past(r_busy, 2)) |-> $past(r_v1, 2))
        else $error("result strobe without an accepted target");
`endif

endmodule
`default_nettype wire
